// File: src/shp_pkg.sv
package shp_pkg;

  // Reset values of the configuration registers.
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hA1;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;
  localparam logic [7:0] MAX_LEN_RST     = 8'd199;

  // Packet type bytes.
  localparam logic [7:0] TYPE_STICK  = 8'hF0;
  localparam logic [7:0] TYPE_PREDEF = 8'h90;
  localparam logic [7:0] TYPE_TASK   = 8'h60;

  localparam logic [7:0] CRC_POLY = 8'h07;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

  typedef enum logic [1:0] {
    KIND_STICK    = 2'd0,
    KIND_PREDEF   = 2'd1,
    KIND_PAYLOAD  = 2'd2,
    KIND_TASK_END = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_t           kind;
    logic [3:0][7:0] sticks;
    logic [7:0]      task_number;
    logic [7:0]      payload;
    logic            crc_good;
  } result_t;

  // One byte through the CRC-8 shift register, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: src/shp_parser.sv
module shp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  shp_pkg::cfg_t    cfg,
  output logic             res_valid,
  output shp_pkg::result_t res
);

  typedef enum logic [3:0] {
    PH_HUNT      = 4'd0,
    PH_FIRST     = 4'd1,
    PH_TYPE      = 4'd2,
    PH_STICK     = 4'd3,
    PH_STICK_CRC = 4'd4,
    PH_PRE_ID    = 4'd5,
    PH_PRE_CRC   = 4'd6,
    PH_TASK_LEN  = 4'd7,
    PH_TASK_DATA = 4'd8,
    PH_TASK_CRC  = 4'd9,
    PH_SKIP      = 4'd10
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [3:0][7:0] sticks_r, sticks_nxt;
  logic [7:0]      task_id_r, task_id_nxt;
  logic [7:0]      len_r, len_nxt;
  logic [7:0]      seen_r, seen_nxt;
  logic [8:0]      seen_inc;
  logic            t_first;
  logic [7:0]      t_crc;

  assign seen_inc = {1'b0, seen_r} + 9'd1;
  // Rescan of the second sync byte after an unknown type byte.
  assign t_first  = (cfg.sync_second == cfg.sync_first);
  assign t_crc    = shp_pkg::crc8_byte(8'd0, cfg.sync_second);

  always_comb begin
    phase_nxt   = phase_r;
    crc_nxt     = crc_r;
    sticks_nxt  = sticks_r;
    task_id_nxt = task_id_r;
    len_nxt     = len_r;
    seen_nxt    = seen_r;
    res_valid   = 1'b0;
    res         = '0;
    case (phase_r)
      PH_FIRST: begin
        if (rx_byte == cfg.sync_second) begin
          crc_nxt   = shp_pkg::crc8_byte(crc_r, rx_byte);
          phase_nxt = PH_TYPE;
        end else if (rx_byte == cfg.sync_first) begin
          crc_nxt   = shp_pkg::crc8_byte(8'd0, rx_byte);
          phase_nxt = PH_FIRST;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_TYPE: begin
        if (rx_byte == shp_pkg::TYPE_STICK || rx_byte == shp_pkg::TYPE_PREDEF ||
            rx_byte == shp_pkg::TYPE_TASK) begin
          crc_nxt  = shp_pkg::crc8_byte(crc_r, rx_byte);
          seen_nxt = '0;
          if (rx_byte == shp_pkg::TYPE_STICK) begin
            phase_nxt = PH_STICK;
          end else if (rx_byte == shp_pkg::TYPE_PREDEF) begin
            phase_nxt = PH_PRE_ID;
          end else begin
            phase_nxt = PH_TASK_LEN;
          end
        end else if (t_first && rx_byte == cfg.sync_second) begin
          crc_nxt   = shp_pkg::crc8_byte(t_crc, rx_byte);
          phase_nxt = PH_TYPE;
        end else if (rx_byte == cfg.sync_first) begin
          crc_nxt   = shp_pkg::crc8_byte(8'd0, rx_byte);
          phase_nxt = PH_FIRST;
        end else begin
          crc_nxt   = t_first ? t_crc : crc_r;
          phase_nxt = PH_HUNT;
        end
      end
      PH_STICK: begin
        sticks_nxt[seen_r[1:0]] = rx_byte;
        crc_nxt  = shp_pkg::crc8_byte(crc_r, rx_byte);
        seen_nxt = seen_inc[7:0];
        if (seen_inc >= 9'd4) begin
          phase_nxt = PH_STICK_CRC;
        end
      end
      PH_STICK_CRC: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == crc_r) begin
          res_valid  = 1'b1;
          res.kind   = shp_pkg::KIND_STICK;
          res.sticks = sticks_r;
        end
      end
      PH_PRE_ID: begin
        task_id_nxt = rx_byte;
        crc_nxt     = shp_pkg::crc8_byte(crc_r, rx_byte);
        phase_nxt   = PH_PRE_CRC;
      end
      PH_PRE_CRC: begin
        phase_nxt = PH_HUNT;
        if (rx_byte == crc_r && task_id_r != 8'd0) begin
          res_valid       = 1'b1;
          res.kind        = shp_pkg::KIND_PREDEF;
          res.task_number = task_id_r;
        end
      end
      PH_TASK_LEN: begin
        crc_nxt  = shp_pkg::crc8_byte(crc_r, rx_byte);
        len_nxt  = rx_byte;
        seen_nxt = '0;
        if (rx_byte == 8'd0 || rx_byte > cfg.max_len) begin
          phase_nxt = PH_SKIP;
        end else begin
          phase_nxt = PH_TASK_DATA;
        end
      end
      PH_TASK_DATA: begin
        crc_nxt  = shp_pkg::crc8_byte(crc_r, rx_byte);
        seen_nxt = seen_inc[7:0];
        if (seen_inc >= {1'b0, len_r}) begin
          phase_nxt = PH_TASK_CRC;
        end
        res_valid   = 1'b1;
        res.kind    = shp_pkg::KIND_PAYLOAD;
        res.payload = rx_byte;
      end
      PH_TASK_CRC: begin
        phase_nxt    = PH_HUNT;
        res_valid    = 1'b1;
        res.kind     = shp_pkg::KIND_TASK_END;
        res.crc_good = (rx_byte == crc_r);
      end
      PH_SKIP: begin
        // The skipped run is the length byte's value plus one byte.
        if (seen_r >= len_r) begin
          phase_nxt = PH_HUNT;
        end else begin
          seen_nxt = seen_inc[7:0];
        end
      end
      default: begin
        if (rx_byte == cfg.sync_first) begin
          crc_nxt   = shp_pkg::crc8_byte(8'd0, rx_byte);
          phase_nxt = PH_FIRST;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      crc_r   <= '0;
      len_r   <= '0;
      seen_r  <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      crc_r     <= crc_nxt;
      len_r     <= len_nxt;
      seen_r    <= seen_nxt;
      sticks_r  <= sticks_nxt;
      task_id_r <= task_id_nxt;
    end
  end

endmodule

// File: src/shp_out_stage.sv
module shp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             res_valid,
  input  shp_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output shp_pkg::result_t res_q
);

  logic             valid_r;
  shp_pkg::result_t res_r;

  // The register can take a new result when empty or when its request leaves now.
  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// File: src/sync_header_packet_deframer_crc8_top.sv
// Sync-header packet deframer with CRC-8 (polynomial 0x07). Takes one received
// byte per request and sustains one byte per clock cycle while out_ready is
// high; a byte passes the input register, then the result register. That rate
// is set by the single parse step between these registers, which does the CRC
// update and phase transition of one byte combinationally. Each byte gives at
// most one result: a stick packet, a predefined task, a task payload byte
// (passed on as it arrives) or a task end carrying crc_good. The user must
// write the configuration registers through the cfg channel only while no
// request is in flight; the block does not enforce it; cfg_ready is always high.
module sync_header_packet_deframer_crc8_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_stick_one,
  output logic [7:0] out_stick_two,
  output logic [7:0] out_stick_three,
  output logic [7:0] out_stick_four,
  output logic [7:0] out_task_number,
  output logic [7:0] out_payload_byte,
  output logic       out_crc_good,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  shp_pkg::cfg_t    cfg_r;
  logic             in_valid_r;
  logic [7:0]       in_byte_r;
  logic             advance;
  logic             step;
  logic             res_valid;
  shp_pkg::result_t res;
  shp_pkg::result_t res_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = !in_valid_r || advance;
  assign step      = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= shp_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= shp_pkg::SYNC_SECOND_RST;
      cfg_r.max_len     <= shp_pkg::MAX_LEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        shp_pkg::CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data;
        shp_pkg::CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_data;
        shp_pkg::CFG_MAX_LEN:     cfg_r.max_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  shp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  shp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (advance),
    .res_q     (res_q)
  );

  assign out_result_kind  = res_q.kind;
  assign out_stick_one    = res_q.sticks[0];
  assign out_stick_two    = res_q.sticks[1];
  assign out_stick_three  = res_q.sticks[2];
  assign out_stick_four   = res_q.sticks[3];
  assign out_task_number  = res_q.task_number;
  assign out_payload_byte = res_q.payload;
  assign out_crc_good     = res_q.crc_good;

endmodule

// File: src/shp_checker.sv
module shp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_stick_one,
  input logic [7:0] out_stick_two,
  input logic [7:0] out_stick_three,
  input logic [7:0] out_stick_four,
  input logic [7:0] out_task_number,
  input logic [7:0] out_payload_byte,
  input logic       out_crc_good
);

  // A stalled result request keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_payload_byte) && $stable(out_crc_good) && $stable(out_task_number))
    else $error("result changed while stalled");

  a_stick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != shp_pkg::KIND_STICK |->
      out_stick_one == 8'd0 && out_stick_two == 8'd0 &&
      out_stick_three == 8'd0 && out_stick_four == 8'd0)
    else $error("stick fields set outside a stick packet");

  a_task_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == shp_pkg::KIND_PREDEF) == (out_task_number != 8'd0))
    else $error("predefined task id does not match result kind");

  a_crc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != shp_pkg::KIND_TASK_END |-> !out_crc_good)
    else $error("crc_good set outside task end");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != shp_pkg::KIND_PAYLOAD |-> out_payload_byte == 8'd0)
    else $error("payload byte set outside a payload result");

endmodule

bind sync_header_packet_deframer_crc8_top shp_checker u_shp_checker (.*);
